[hw/rtl/leti_pkg.sv]
package leti_pkg;

  localparam int STATE_FRAC_BITS = 40;

  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_INTERVAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SHIFT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT    = 3'd6;

  localparam logic [31:0] SIGMA_RESET         = 32'd167772160;
  localparam logic [31:0] RHO_RESET           = 32'd469762048;
  localparam logic [31:0] BETA_RESET          = 32'd44739243;
  localparam logic [39:0] TIME_STEP_RESET     = 40'd1099512;
  localparam logic [15:0] DRAW_INTERVAL_RESET = 16'd10;
  localparam logic [29:0] VIEW_SHIFT_RESET    = 30'd322122547;
  localparam logic [31:0] STEP_LIMIT_RESET    = 32'd50000001;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [2:0] A_YMX = 3'd0;
  localparam logic [2:0] A_X   = 3'd1;
  localparam logic [2:0] A_Z   = 3'd2;
  localparam logic [2:0] A_D   = 3'd3;
  localparam logic [2:0] A_SCL = 3'd4;

  localparam logic [2:0] B_SIGMA = 3'd0;
  localparam logic [2:0] B_RHO   = 3'd1;
  localparam logic [2:0] B_BETA  = 3'd2;
  localparam logic [2:0] B_TS    = 3'd3;
  localparam logic [2:0] B_Y     = 3'd4;
  localparam logic [2:0] B_Z     = 3'd5;
  localparam logic [2:0] B_RECIP = 3'd6;

  localparam logic [2:0] WR_LOAD      = 3'd0;
  localparam logic [2:0] WR_LOAD_SUBY = 3'd1;
  localparam logic [2:0] WR_LOAD_SH   = 3'd2;
  localparam logic [2:0] WR_SUB       = 3'd3;
  localparam logic [2:0] WR_SUB_SH    = 3'd4;
  localparam logic [2:0] WR_UPD       = 3'd5;
  localparam logic [2:0] WR_OUT       = 3'd6;

  localparam int SCALED_W  = 38;
  localparam int OUT_QW    = 36;
  localparam int OUT_SHIFT = 45;
  localparam logic [39:0] OUT_OFFSET = 40'd214748364800;
  localparam logic [39:0] RECIP50    = 40'd703687441777;
  localparam logic signed [OUT_QW-1:0] OUT_BIAS = 36'sh1_0000_0000;

  localparam logic [2:0] STEP_LAST = 3'd7;
  localparam logic [2:0] OUT_LAST  = 3'd2;

  typedef struct packed {
    logic              operation;
    logic signed [47:0] start_x;
    logic signed [47:0] start_y;
    logic signed [47:0] start_z;
    logic signed [47:0] perturb_z;
  } leti_in_t;

  typedef struct packed {
    logic signed [31:0] first_px;
    logic signed [31:0] first_py;
    logic signed [31:0] first_pz;
    logic signed [31:0] second_px;
    logic signed [31:0] second_py;
    logic signed [31:0] second_pz;
  } leti_out_t;

  typedef struct packed {
    logic [31:0] sigma;
    logic [31:0] rho;
    logic [31:0] beta;
    logic [39:0] time_step;
    logic [29:0] view_shift;
  } leti_coef_t;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [2:0] wr_mode;
    logic [1:0] coord;
  } leti_op_t;

  typedef struct packed {
    logic     restart;
    logic     op_load;
    logic     mul_start;
    logic     out_load;
    logic     traj;
    leti_op_t op;
  } leti_cmd_t;

  typedef struct packed {
    logic mul_done;
  } leti_stat_t;

  function automatic leti_op_t leti_step_op(input logic [2:0] idx);
    leti_op_t op;
    unique case (idx)
      3'd0: op = '{a_sel: A_YMX, b_sel: B_SIGMA, wr_mode: WR_LOAD,      coord: 2'd0};
      3'd1: op = '{a_sel: A_X,   b_sel: B_RHO,   wr_mode: WR_LOAD_SUBY, coord: 2'd1};
      3'd2: op = '{a_sel: A_X,   b_sel: B_Z,     wr_mode: WR_SUB_SH,    coord: 2'd1};
      3'd3: op = '{a_sel: A_X,   b_sel: B_Y,     wr_mode: WR_LOAD_SH,   coord: 2'd2};
      3'd4: op = '{a_sel: A_Z,   b_sel: B_BETA,  wr_mode: WR_SUB,       coord: 2'd2};
      3'd5: op = '{a_sel: A_D,   b_sel: B_TS,    wr_mode: WR_UPD,       coord: 2'd0};
      3'd6: op = '{a_sel: A_D,   b_sel: B_TS,    wr_mode: WR_UPD,       coord: 2'd1};
      default: op = '{a_sel: A_D, b_sel: B_TS,   wr_mode: WR_UPD,       coord: 2'd2};
    endcase
    return op;
  endfunction

endpackage

[hw/rtl/leti_mul.sv]
module leti_mul #(
  parameter int OP_W = leti_pkg::STATE_FRAC_BITS + 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [OP_W-1:0]   a,
  input  logic signed [OP_W-1:0]   b,
  output logic                     done,
  output logic signed [2*OP_W-1:0] p
);

  localparam int NCH  = (OP_W + 31) / 32;
  localparam int MAW  = NCH * 32;
  localparam int ACCW = 2 * MAW;
  localparam int PW   = 2 * OP_W;
  localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SHW  = $clog2(2 * NCH);

  logic [OP_W-1:0] amag, bmag;
  logic [MAW-1:0]  ma, mb;
  logic            neg;
  logic [CW-1:0]   ia, ib;
  logic            issue;
  logic            last_pair;
  logic [63:0]     pp;
  logic [SHW-1:0]  pp_sh;
  logic            pp_vld, pp_last;
  logic            fin;
  logic [ACCW-1:0] acc;

  assign amag = a[OP_W-1] ? (~a + 1'b1) : a;
  assign bmag = b[OP_W-1] ? (~b + 1'b1) : b;
  assign last_pair = (ia == CW'(NCH - 1)) && (ib == CW'(NCH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      issue  <= 1'b0;
      pp_vld <= 1'b0;
      fin    <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= fin;
      fin    <= pp_vld && pp_last;
      pp_vld <= issue;
      if (start) begin
        issue <= 1'b1;
      end else if (issue && last_pair) begin
        issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= MAW'(amag);
      mb  <= MAW'(bmag);
      neg <= a[OP_W-1] ^ b[OP_W-1];
      ia  <= '0;
      ib  <= '0;
      acc <= '0;
    end else if (issue) begin
      pp      <= ma[ia*32 +: 32] * mb[ib*32 +: 32];
      pp_sh   <= SHW'(ia) + SHW'(ib);
      pp_last <= last_pair;
      if (ib == CW'(NCH - 1)) begin
        ib <= '0;
        ia <= ia + 1'b1;
      end else begin
        ib <= ib + 1'b1;
      end
    end
    if (pp_vld) begin
      acc <= acc + (ACCW'(pp) << {pp_sh, 5'd0});
    end
    if (fin) begin
      p <= neg ? (~acc[PW-1:0] + 1'b1) : acc[PW-1:0];
    end
  end

endmodule

[hw/rtl/leti_dp.sv]
module leti_dp #(
  parameter int STATE_FRAC_BITS = leti_pkg::STATE_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  leti_pkg::leti_cmd_t  cmd,
  output leti_pkg::leti_stat_t stat,
  input  leti_pkg::leti_in_t   item,
  input  leti_pkg::leti_coef_t coef,
  output leti_pkg::leti_out_t  result
);

  localparam int F      = STATE_FRAC_BITS;
  localparam int SW     = F + 8;
  localparam int MW     = SW + 10;
  localparam int PW     = 2 * MW;
  localparam int DW     = SW + 34;
  localparam int XW     = SW + 11;
  localparam int EW     = SW + 48;
  localparam int QW     = leti_pkg::OUT_QW;
  localparam int SH_D   = F - 24;
  localparam int LS_IN  = (F >= 40) ? F - 40 : 0;
  localparam int RS_IN  = (F >= 40) ? 0 : 40 - F;
  localparam int LS_OUT = (F >= 30) ? 0 : 30 - F;
  localparam int RS_OUT = (F >= 30) ? F - 30 : 0;

  localparam logic [63:0] ONE64 = 64'd1 << F;
  localparam logic [63:0] Z1_64 = 64'd10 * ONE64;
  localparam logic [63:0] Z2_64 = Z1_64 + (ONE64 + 64'd500) / 64'd1000;
  localparam logic signed [SW-1:0] POS_ONE = SW'(ONE64);
  localparam logic signed [SW-1:0] POS_Z1  = SW'(Z1_64);
  localparam logic signed [SW-1:0] POS_Z2  = SW'(Z2_64);

  function automatic logic signed [SW-1:0] sat_xw(input logic signed [XW-1:0] v);
    logic [XW-SW:0] top;
    top = v[XW-1:SW-1];
    if ((&top) || !(|top)) begin
      return v[SW-1:0];
    end
    return v[XW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [QW-1:0] v);
    logic [QW-32:0] top;
    top = v[QW-1:31];
    if ((&top) || !(|top)) begin
      return v[31:0];
    end
    return v[QW-1] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [SW-1:0] to_state(input logic signed [47:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    e = e <<< LS_IN;
    e = e >>> RS_IN;
    return e[SW-1:0];
  endfunction

  logic signed [SW-1:0] pos [2][3];
  logic signed [DW-1:0] dreg [3];
  logic signed [31:0]   res [2][3];

  logic signed [SW-1:0] px, py, pz, psel;
  logic signed [DW-1:0] dsel;
  logic signed [EW-1:0] pe;
  logic signed [leti_pkg::SCALED_W-1:0] pscl;
  logic [39:0]          usc;
  logic signed [MW-1:0] opa, opb, opa_r, opb_r;
  logic signed [PW-1:0] pw;
  logic                 mul_done;
  logic signed [XW-1:0] upd_sum;
  logic signed [QW-1:0] q;
  logic signed [SW-1:0] st_z;

  assign px = pos[cmd.traj][0];
  assign py = pos[cmd.traj][1];
  assign pz = pos[cmd.traj][2];

  always_comb begin
    unique case (cmd.op.coord)
      2'd0:    begin psel = px; dsel = dreg[0]; end
      2'd1:    begin psel = py; dsel = dreg[1]; end
      default: begin psel = pz; dsel = dreg[2]; end
    endcase
  end

  always_comb begin
    pe   = EW'(psel) <<< LS_OUT;
    pe   = pe >>> RS_OUT;
    pscl = pe[leti_pkg::SCALED_W-1:0];
    usc  = 40'(pscl) + leti_pkg::OUT_OFFSET;
  end

  always_comb begin
    unique case (cmd.op.a_sel)
      leti_pkg::A_YMX: opa = MW'(py) - MW'(px);
      leti_pkg::A_X:   opa = MW'(px);
      leti_pkg::A_Z:   opa = MW'(pz);
      leti_pkg::A_D:   opa = dsel[DW-1:24];
      default:         opa = MW'(usc);
    endcase
    unique case (cmd.op.b_sel)
      leti_pkg::B_SIGMA: opb = MW'(coef.sigma);
      leti_pkg::B_RHO:   opb = MW'(coef.rho);
      leti_pkg::B_BETA:  opb = MW'(coef.beta);
      leti_pkg::B_TS:    opb = MW'(coef.time_step);
      leti_pkg::B_Y:     opb = MW'(py);
      leti_pkg::B_Z:     opb = MW'(pz);
      default:           opb = MW'(leti_pkg::RECIP50);
    endcase
  end

  leti_mul #(.OP_W(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (opa_r),
    .b     (opb_r),
    .done  (mul_done),
    .p     (pw)
  );

  assign stat.mul_done = mul_done;

  assign upd_sum = XW'(psel) + XW'(pw >>> 40);
  assign st_z    = to_state(item.start_z);

  always_comb begin
    q = QW'(pw >>> leti_pkg::OUT_SHIFT) - leti_pkg::OUT_BIAS;
    if (cmd.traj && (cmd.op.coord == 2'd0)) begin
      q = q + QW'(coef.view_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0][0] <= POS_ONE;
      pos[0][1] <= POS_ONE;
      pos[0][2] <= POS_Z1;
      pos[1][0] <= POS_ONE;
      pos[1][1] <= POS_ONE;
      pos[1][2] <= POS_Z2;
    end else if (cmd.restart) begin
      pos[0][0] <= to_state(item.start_x);
      pos[0][1] <= to_state(item.start_y);
      pos[0][2] <= st_z;
      pos[1][0] <= to_state(item.start_x);
      pos[1][1] <= to_state(item.start_y);
      pos[1][2] <= sat_xw(XW'(st_z) + XW'(to_state(item.perturb_z)));
    end else if (mul_done && (cmd.op.wr_mode == leti_pkg::WR_UPD)) begin
      pos[cmd.traj][cmd.op.coord] <= sat_xw(upd_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      opa_r <= opa;
      opb_r <= opb;
    end
    if (mul_done) begin
      unique case (cmd.op.wr_mode)
        leti_pkg::WR_LOAD:      dreg[cmd.op.coord] <= DW'(pw);
        leti_pkg::WR_LOAD_SUBY: dreg[cmd.op.coord] <= DW'(pw) - (DW'(py) <<< 24);
        leti_pkg::WR_LOAD_SH:   dreg[cmd.op.coord] <= DW'(pw >>> SH_D);
        leti_pkg::WR_SUB:       dreg[cmd.op.coord] <= dsel - DW'(pw);
        leti_pkg::WR_SUB_SH:    dreg[cmd.op.coord] <= dsel - DW'(pw >>> SH_D);
        leti_pkg::WR_OUT:       res[cmd.traj][cmd.op.coord] <= sat32(q);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      result.first_px  <= res[0][0];
      result.first_py  <= res[0][1];
      result.first_pz  <= res[0][2];
      result.second_px <= res[1][0];
      result.second_py <= res[1][1];
      result.second_pz <= res[1][2];
    end
  end

endmodule

[hw/rtl/leti_ctrl.sv]
module leti_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 operation,
  input  logic [15:0]          draw_interval,
  input  logic [31:0]          step_limit,
  input  leti_pkg::leti_stat_t stat,
  output leti_pkg::leti_cmd_t  cmd,
  output logic                 result_valid,
  input  logic                 result_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic PH_STEP = 1'b0;
  localparam logic PH_OUT  = 1'b1;

  logic [2:0]  state;
  logic        phase;
  logic        traj;
  logic [2:0]  idx;
  logic        emit;
  logic [31:0] steps_done;
  logic [15:0] dec_count;
  logic [15:0] dec_next;
  logic        accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign dec_next   = dec_count + 16'd1;

  always_comb begin
    cmd.restart   = accept && (operation == leti_pkg::OP_RESTART);
    cmd.op_load   = (state == S_LOAD);
    cmd.mul_start = (state == S_START);
    cmd.out_load  = (state == S_DONE) && (!result_valid || result_ready);
    cmd.traj      = traj;
    if (phase == PH_OUT) begin
      cmd.op.a_sel   = leti_pkg::A_SCL;
      cmd.op.b_sel   = leti_pkg::B_RECIP;
      cmd.op.wr_mode = leti_pkg::WR_OUT;
      cmd.op.coord   = idx[1:0];
    end else begin
      cmd.op = leti_pkg::leti_step_op(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_STEP;
      traj         <= 1'b0;
      idx          <= '0;
      emit         <= 1'b0;
      steps_done   <= '0;
      dec_count    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == leti_pkg::OP_RESTART) begin
              steps_done <= '0;
              dec_count  <= '0;
            end else if (steps_done < step_limit) begin
              steps_done <= steps_done + 32'd1;
              if (dec_next >= draw_interval) begin
                emit      <= 1'b1;
                dec_count <= '0;
              end else begin
                emit      <= 1'b0;
                dec_count <= dec_next;
              end
              phase <= PH_STEP;
              traj  <= 1'b0;
              idx   <= '0;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD:  state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (stat.mul_done) begin
            if (idx == ((phase == PH_STEP) ? leti_pkg::STEP_LAST : leti_pkg::OUT_LAST)) begin
              idx <= '0;
              if (!traj) begin
                traj  <= 1'b1;
                state <= S_LOAD;
              end else if ((phase == PH_STEP) && emit) begin
                phase <= PH_OUT;
                traj  <= 1'b0;
                state <= S_LOAD;
              end else if (phase == PH_OUT) begin
                state <= S_DONE;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              idx   <= idx + 3'd1;
              state <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            phase <= PH_STEP;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/lorenz_euler_twin_integrator.sv]
// Twin Lorenz integrator: two trajectories advanced side by side by forward Euler.
// Item channel (item_valid/item_ready/item): a restart word loads both trajectories
// and clears the step and draw counters; a tick word advances both by one step
// unless step_limit steps have already been done since restart.
// Result channel (result_valid/result_ready/result): every draw_interval steps one
// word carries both points scaled by 1/50, view_shift added to the second x.
// Config port (cfg_write/cfg_index/cfg_data): write while no word is in flight.
// Every multiply runs on one shared 32x32 multiplier over C*C partial products,
// C = ceil((STATE_FRAC_BITS + 18) / 32). A tick needs 16 multiplies; a tick that
// emits adds 6 multiplies for the scaling. No new item is taken until the
// current one is through. After the last multiply the result is loaded into
// the output register once that register is free.
// Reset loads the default trajectories and registers and empties the result.
// A result waits in the output register while the receiver stalls; the next item
// is still taken, and only a second finished result stalls the item channel.
module lorenz_euler_twin_integrator #(
  parameter int STATE_FRAC_BITS = leti_pkg::STATE_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  leti_pkg::leti_in_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output leti_pkg::leti_out_t                 result,
  input  logic                                cfg_write,
  input  logic [leti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [leti_pkg::CFG_W-1:0]          cfg_data
);

  leti_pkg::leti_coef_t coef;
  logic [15:0]          draw_interval;
  logic [31:0]          step_limit;
  leti_pkg::leti_cmd_t  cmd;
  leti_pkg::leti_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.sigma      <= leti_pkg::SIGMA_RESET;
      coef.rho        <= leti_pkg::RHO_RESET;
      coef.beta       <= leti_pkg::BETA_RESET;
      coef.time_step  <= leti_pkg::TIME_STEP_RESET;
      coef.view_shift <= leti_pkg::VIEW_SHIFT_RESET;
      draw_interval   <= leti_pkg::DRAW_INTERVAL_RESET;
      step_limit      <= leti_pkg::STEP_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        leti_pkg::CFG_SIGMA:         coef.sigma      <= cfg_data[31:0];
        leti_pkg::CFG_RHO:           coef.rho        <= cfg_data[31:0];
        leti_pkg::CFG_BETA:          coef.beta       <= cfg_data[31:0];
        leti_pkg::CFG_TIME_STEP:     coef.time_step  <= cfg_data[39:0];
        leti_pkg::CFG_DRAW_INTERVAL: draw_interval   <= cfg_data[15:0];
        leti_pkg::CFG_VIEW_SHIFT:    coef.view_shift <= cfg_data[29:0];
        leti_pkg::CFG_STEP_LIMIT:    step_limit      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  leti_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .operation     (item.operation),
    .draw_interval (draw_interval),
    .step_limit    (step_limit),
    .stat          (stat),
    .cmd           (cmd),
    .result_valid  (result_valid),
    .result_ready  (result_ready)
  );

  leti_dp #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .item   (item),
    .coef   (coef),
    .result (result)
  );

endmodule
